>>> rtl/core/qsv_pkg.sv
// ----------------------------------------------------------------------------
// Quantum state-vector engine package
// Shared widths, codes and types for the gate engine.
// ----------------------------------------------------------------------------
package qsv_pkg;

  localparam int QUBIT_COUNT_DEF = 6;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAT_W           = 18;
  localparam int MAT_FRAC        = 16;
  localparam int QW              = 3;
  localparam int IDX_W           = 6;
  localparam int PROB_W          = 17;

  typedef enum logic [2:0] {
    MODE_MATRIX = 3'd0,
    MODE_CX     = 3'd1,
    MODE_CZ     = 3'd2,
    MODE_SWAP   = 3'd3,
    MODE_CCX    = 3'd4,
    MODE_RESET  = 3'd5,
    MODE_READ   = 3'd6,
    MODE_NOP    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_WRITE,
    ST_EMIT,
    ST_ACK
  } state_t;

endpackage

>>> rtl/core/qsv_if.sv
// ----------------------------------------------------------------------------
// Gate engine channels
// Valid/ready channels for gate commands and results.
// ----------------------------------------------------------------------------
interface qsv_gate_if;
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic [2:0]          target_qubit;
  logic [2:0]          control_qubit;
  logic [2:0]          second_control_qubit;
  logic signed [17:0]  m00_re, m00_im, m01_re, m01_im;
  logic signed [17:0]  m10_re, m10_im, m11_re, m11_im;
  modport source (output valid, mode, target_qubit, control_qubit, second_control_qubit,
                  m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im,
                  input ready);
  modport sink (input valid, mode, target_qubit, control_qubit, second_control_qubit,
                m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im,
                output ready);
endinterface

interface qsv_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  basis_index;
  logic [16:0] probability;
  logic        last;
  modport source (output valid, kind, basis_index, probability, last, input ready);
  modport sink (input valid, kind, basis_index, probability, last, output ready);
endinterface

>>> rtl/core/qsv_butterfly.sv
// ----------------------------------------------------------------------------
// Matrix butterfly
// Two-stage pipelined 2x2 complex matrix product with rounding and saturation.
// ----------------------------------------------------------------------------
module qsv_butterfly #(
  parameter int FRAC_BITS = qsv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic signed [17:0]          m [8],
  input  logic signed [FRAC_BITS+1:0] ar, ai, br, bi,
  output logic signed [FRAC_BITS+1:0] nar, nai, nbr, nbi
);
  localparam int AW = FRAC_BITS + 2;
  localparam int PW = AW + 18;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] p [16];
  logic signed [AW-1:0] av [4];

  assign av[0] = ar;
  assign av[1] = ai;
  assign av[2] = br;
  assign av[3] = bi;

  // Product order per output: terms for a_re, a_im, b_re, b_im coefficients.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 2; r++) begin
      p[r*8+0] <= m[r*4+0] * av[0];
      p[r*8+1] <= m[r*4+1] * av[1];
      p[r*8+2] <= m[r*4+2] * av[2];
      p[r*8+3] <= m[r*4+3] * av[3];
      p[r*8+4] <= m[r*4+0] * av[1];
      p[r*8+5] <= m[r*4+1] * av[0];
      p[r*8+6] <= m[r*4+2] * av[3];
      p[r*8+7] <= m[r*4+3] * av[2];
    end
  end

  function automatic logic signed [AW-1:0] fin(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] q;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    y  = s + (SW'(1) <<< (qsv_pkg::MAT_FRAC - 1));
    q  = y >>> qsv_pkg::MAT_FRAC;
    hi = (SW'(1) <<< (AW - 1)) - SW'(1);
    lo = -hi - SW'(1);
    if (q > hi) fin = hi[AW-1:0];
    else if (q < lo) fin = lo[AW-1:0];
    else fin = q[AW-1:0];
  endfunction

  logic signed [SW-1:0] s0r, s0i, s1r, s1i;
  always_comb begin
    s0r = SW'(p[0]) - SW'(p[1]) + SW'(p[2]) - SW'(p[3]);
    s0i = SW'(p[4]) + SW'(p[5]) + SW'(p[6]) + SW'(p[7]);
    s1r = SW'(p[8]) - SW'(p[9]) + SW'(p[10]) - SW'(p[11]);
    s1i = SW'(p[12]) + SW'(p[13]) + SW'(p[14]) + SW'(p[15]);
  end

  always_ff @(posedge clk) begin
    nar <= fin(s0r);
    nai <= fin(s0i);
    nbr <= fin(s1r);
    nbi <= fin(s1i);
  end
endmodule

>>> rtl/core/qubit_state_vector_gate_engine.sv
// ----------------------------------------------------------------------------
// Qubit state-vector gate engine
// Holds 2^QUBIT_COUNT complex amplitudes in one memory and applies gates.
// ----------------------------------------------------------------------------
// Usage: gates arrive on the gate channel, one transaction per gate, and
// results leave on the result channel. A gate other than readout or reset
// walks the amplitude memory one index pair at a time: read both entries,
// two butterfly stages, write both back. Its acknowledgment (last set)
// follows the write of the last pair, and the next gate can be taken at the
// following clock edge. A reset gate rewrites every entry and then
// acknowledges. Readout streams 2^QUBIT_COUNT probability transactions, each
// through memory read, operand register, square and sum, the next index read
// only once the previous transaction is loaded, and the final one marked
// last. One gate is in flight at a time. The result register holds its
// transaction while the receiver stalls, and the acknowledgment or the
// readout waits for it. After reset a clearing pass loads the ground state;
// the gate channel stays not ready until it ends.
// ----------------------------------------------------------------------------
module qubit_state_vector_gate_engine #(
  parameter int QUBIT_COUNT = qsv_pkg::QUBIT_COUNT_DEF,
  parameter int FRAC_BITS   = qsv_pkg::FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  qsv_gate_if.sink     gate,
  qsv_result_if.source result
);
  localparam int N   = 1 << QUBIT_COUNT;
  localparam int AW  = FRAC_BITS + 2;
  localparam int IW  = (QUBIT_COUNT > 1) ? QUBIT_COUNT : 1;
  localparam int CW  = QUBIT_COUNT + 1;
  localparam int PW2 = 2*AW + 1;
  localparam int PROB_W = qsv_pkg::PROB_W;

  localparam logic [CW-1:0] LAST_PAIR = CW'(N/2 - 1);
  localparam logic [CW-1:0] LAST_IDX  = CW'(N - 1);
  localparam logic [2*AW-1:0] ONE_AMP = (2*AW)'(1) << (AW + FRAC_BITS);
  localparam logic [PW2-1:0] PROB_MAX = PW2'((1 << PROB_W) - 1);

  logic [2*AW-1:0] mem [N];

  qsv_pkg::state_t state, state_next;
  qsv_pkg::mode_t  mode;
  logic [qsv_pkg::QW-1:0] tq, cq, c2;
  logic signed [qsv_pkg::MAT_W-1:0] m [8];
  logic [CW-1:0] cnt;
  logic clearing;
  logic [1:0] calc_cnt;
  logic [IW-1:0] ia, ib, sa;
  logic [IW-1:0] tmask, cmask, c2mask;
  logic [2*AW-1:0] rda, rdb;
  logic signed [AW-1:0] nar, nai, nbr, nbi;
  logic in_rng, act, swp, neg, mat, wa, wb;
  logic [IW-1:0] raddr_a;
  logic [2*AW-1:0] wda, wdb;
  logic signed [AW-1:0] re_r, im_r;
  logic signed [2*AW-1:0] sq_re, sq_im;
  logic [PW2-1:0] psum, prob_r;
  logic [PROB_W-1:0] prob_sat;
  logic res_busy, res_load;

  // Bit mask of a qubit; a qubit beyond the store gives an empty mask.
  function automatic logic [IW-1:0] qmask(input logic [qsv_pkg::QW-1:0] q);
    qmask = (q < 3'(QUBIT_COUNT)) ? (IW'(1) << q) : '0;
  endfunction

  // Inserts a zero at bit position b of k, which yields the low entry of a pair.
  function automatic logic [IW-1:0] ins0(input logic [IW-1:0] k,
                                         input logic [qsv_pkg::QW-1:0] b);
    logic [IW-1:0] lowm;
    lowm = (IW'(1) << b) - IW'(1);
    ins0 = ((k & ~lowm) << 1) | (k & lowm);
  endfunction

  function automatic logic signed [AW-1:0] sneg(input logic signed [AW-1:0] v);
    logic signed [AW:0] t;
    t = -{v[AW-1], v};
    if (t > (AW+1)'((1 <<< (AW-1)) - 1)) sneg = {1'b0, {(AW-1){1'b1}}};
    else sneg = t[AW-1:0];
  endfunction

  always_comb begin
    tmask  = qmask(tq);
    cmask  = qmask(cq);
    c2mask = qmask(c2);
    unique case (mode)
      qsv_pkg::MODE_MATRIX: in_rng = |tmask;
      qsv_pkg::MODE_CX, qsv_pkg::MODE_CZ, qsv_pkg::MODE_SWAP:
        in_rng = (|tmask) && (|cmask);
      qsv_pkg::MODE_CCX: in_rng = (|tmask) && (|cmask) && (|c2mask);
      default: in_rng = 1'b1;
    endcase
    ia  = ins0(cnt[IW-1:0], tq);
    ib  = ia | tmask;
    sa  = ia;
    mat = (mode == qsv_pkg::MODE_MATRIX) && in_rng;
    act = 1'b0;
    swp = 1'b0;
    neg = 1'b0;
    unique case (mode)
      qsv_pkg::MODE_CX: act = in_rng && (cq != tq) && (|(ia & cmask));
      qsv_pkg::MODE_CCX:
        act = in_rng && (cq != tq) && (c2 != tq) && (|(ia & cmask)) && (|(ia & c2mask));
      qsv_pkg::MODE_CZ: neg = in_rng && (|(ib & cmask));
      qsv_pkg::MODE_SWAP: begin
        // The high entry (control clear) trades places with the low entry plus control.
        swp = in_rng && (cq != tq) && !(|(ia & cmask));
        sa  = ia | cmask;
      end
      default: ;
    endcase
    wa = mat || act || swp;
    wb = wa || neg;
  end

  assign gate.ready = (state == qsv_pkg::ST_IDLE) && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qsv_pkg::MODE_NOP;
      tq <= '0;
      cq <= '0;
      c2 <= '0;
    end else if (gate.valid && gate.ready) begin
      mode <= qsv_pkg::mode_t'(gate.mode);
      tq <= gate.target_qubit;
      cq <= gate.control_qubit;
      c2 <= gate.second_control_qubit;
    end
  end

  always_ff @(posedge clk) begin
    if (gate.valid && gate.ready) begin
      m[0] <= gate.m00_re; m[1] <= gate.m00_im; m[2] <= gate.m01_re; m[3] <= gate.m01_im;
      m[4] <= gate.m10_re; m[5] <= gate.m10_im; m[6] <= gate.m11_re; m[7] <= gate.m11_im;
    end
  end

  // Memory reads: registered two-address read.
  assign raddr_a = (state == qsv_pkg::ST_EMIT) ? cnt[IW-1:0] : sa;
  always_ff @(posedge clk) begin
    rda <= mem[raddr_a];
    rdb <= mem[ib];
  end

  qsv_butterfly #(.FRAC_BITS(FRAC_BITS)) u_bfly (
    .clk(clk), .m(m),
    .ar(rda[2*AW-1:AW]), .ai(rda[AW-1:0]),
    .br(rdb[2*AW-1:AW]), .bi(rdb[AW-1:0]),
    .nar(nar), .nai(nai), .nbr(nbr), .nbi(nbi)
  );

  always_comb begin
    if (mat) begin
      wda = {nar, nai};
      wdb = {nbr, nbi};
    end else if (neg) begin
      wda = rda;
      wdb = {sneg(rdb[2*AW-1:AW]), sneg(rdb[AW-1:0])};
    end else begin
      wda = rdb;
      wdb = rda;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || (state == qsv_pkg::ST_WRITE && mode == qsv_pkg::MODE_RESET)) begin
      mem[cnt[IW-1:0]] <= (cnt == '0) ? ONE_AMP : '0;
    end else if (state == qsv_pkg::ST_WRITE) begin
      if (wa) mem[sa] <= wda;
      if (wb) mem[ib] <= wdb;
    end
  end

  // Probability pipeline.
  always_ff @(posedge clk) begin
    re_r  <= rda[2*AW-1:AW];
    im_r  <= rda[AW-1:0];
    sq_re <= re_r * re_r;
    sq_im <= im_r * im_r;
  end
  always_comb begin
    psum     = PW2'(sq_re) + PW2'(sq_im);
    prob_r   = psum >> (2*FRAC_BITS - 16);
    prob_sat = (prob_r > PROB_MAX) ? PROB_MAX[PROB_W-1:0] : prob_r[PROB_W-1:0];
  end

  assign res_busy = result.valid && !result.ready;
  assign res_load = !res_busy &&
                    (((state == qsv_pkg::ST_EMIT) && (calc_cnt == 2'd3)) ||
                     (state == qsv_pkg::ST_ACK));

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (res_load) result.valid <= 1'b1;
    else if (result.ready) result.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (state == qsv_pkg::ST_EMIT) begin
        result.kind <= 1'b1;
        result.basis_index <= 6'(cnt);
        result.probability <= prob_sat;
        result.last <= (cnt == LAST_IDX);
      end else begin
        result.kind <= 1'b0;
        result.basis_index <= '0;
        result.probability <= '0;
        result.last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsv_pkg::ST_IDLE;
      clearing <= 1'b1;
      cnt <= '0;
      calc_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        if (cnt == LAST_IDX) begin
          clearing <= 1'b0;
          cnt <= '0;
        end else cnt <= cnt + 1'b1;
      end else begin
        unique case (state)
          qsv_pkg::ST_IDLE: begin
            cnt <= '0;
            calc_cnt <= '0;
          end
          qsv_pkg::ST_READ: calc_cnt <= '0;
          qsv_pkg::ST_WAIT, qsv_pkg::ST_CALC: calc_cnt <= calc_cnt + 1'b1;
          qsv_pkg::ST_WRITE: cnt <= cnt + 1'b1;
          qsv_pkg::ST_EMIT: begin
            if (res_load) begin
              cnt <= cnt + 1'b1;
              calc_cnt <= '0;
            end else if (calc_cnt != 2'd3) calc_cnt <= calc_cnt + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qsv_pkg::ST_IDLE:
        if (gate.valid && gate.ready) begin
          if (gate.mode == qsv_pkg::MODE_READ) state_next = qsv_pkg::ST_EMIT;
          else if (gate.mode == qsv_pkg::MODE_RESET) state_next = qsv_pkg::ST_WRITE;
          else state_next = qsv_pkg::ST_READ;
        end
      qsv_pkg::ST_READ: state_next = qsv_pkg::ST_WAIT;
      qsv_pkg::ST_WAIT: state_next = qsv_pkg::ST_CALC;
      qsv_pkg::ST_CALC: if (calc_cnt == 2'd2) state_next = qsv_pkg::ST_WRITE;
      qsv_pkg::ST_WRITE:
        if (mode == qsv_pkg::MODE_RESET)
          state_next = (cnt == LAST_IDX) ? qsv_pkg::ST_ACK : qsv_pkg::ST_WRITE;
        else
          state_next = (cnt == LAST_PAIR) ? qsv_pkg::ST_ACK : qsv_pkg::ST_READ;
      qsv_pkg::ST_EMIT:
        if (res_load && cnt == LAST_IDX) state_next = qsv_pkg::ST_IDLE;
      qsv_pkg::ST_ACK: if (res_load) state_next = qsv_pkg::ST_IDLE;
      default: state_next = qsv_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    gate.ready |-> state == qsv_pkg::ST_IDLE)
    else $error("gate taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !gate.ready)
    else $error("gate taken during clearing pass");
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == 1'b0 |-> result.last)
    else $error("acknowledgment without last");
endmodule

>>> tb/sv/qsv_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate engine testbench shared types
// The testbench reuses the block's own channel interfaces; this file only
// carries the small shared types of the test environment.
// ----------------------------------------------------------------------------
package qsv_tb_pkg;

  typedef struct packed {
    logic        kind;
    logic [5:0]  basis_index;
    logic [16:0] probability;
    logic        last;
  } result_item_t;

endpackage

>>> tb/sv/qsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate engine checker
// Watches the gate and result channels, keeps its own copy of the amplitude
// store, predicts every result transaction and compares each field.
// ----------------------------------------------------------------------------
module qsv_checker #(
  parameter int NQ = qsv_pkg::QUBIT_COUNT_DEF
) (
  input logic    clk,
  input logic    rst,
  qsv_gate_if    gate,
  qsv_result_if  result,
  output int     fail_count,
  output int     pending,
  output int     prob_count,
  output int     ack_count
);

  localparam int SIZE = 1 << NQ;
  localparam longint AMP_MAX = (longint'(1) << (qsv_pkg::FRAC_BITS_DEF + 1)) - 1;
  localparam longint AMP_MIN = -AMP_MAX - 1;

  longint amp_re[SIZE];
  longint amp_im[SIZE];
  qsv_tb_pkg::result_item_t expected_results[$];

  function automatic longint clamp_amp(longint v);
    if (v > AMP_MAX) return AMP_MAX;
    if (v < AMP_MIN) return AMP_MIN;
    return v;
  endfunction

  // Round half up, then drop the matrix fraction bits (arithmetic shift floors).
  function automatic longint scale_down(longint x);
    return (x + (longint'(1) << (qsv_pkg::MAT_FRAC - 1))) >>> qsv_pkg::MAT_FRAC;
  endfunction

  task automatic load_ground();
    for (int i = 0; i < SIZE; i++) begin
      amp_re[i] = 0;
      amp_im[i] = 0;
    end
    amp_re[0] = longint'(1) << qsv_pkg::FRAC_BITS_DEF;
  endtask

  task automatic exchange(int a, int b);
    longint t;
    t = amp_re[a]; amp_re[a] = amp_re[b]; amp_re[b] = t;
    t = amp_im[a]; amp_im[a] = amp_im[b]; amp_im[b] = t;
  endtask

  task automatic apply_gate();
    longint m[8];
    longint ar, ai, br, bi;
    int tq, cq, c2, tb, cb, c2b, j;
    qsv_pkg::mode_t md;
    qsv_tb_pkg::result_item_t r;
    md = qsv_pkg::mode_t'(gate.mode);
    tq = gate.target_qubit;
    cq = gate.control_qubit;
    c2 = gate.second_control_qubit;
    m = '{gate.m00_re, gate.m00_im, gate.m01_re, gate.m01_im,
          gate.m10_re, gate.m10_im, gate.m11_re, gate.m11_im};
    tb = 1 << tq;
    cb = 1 << cq;
    c2b = 1 << c2;
    if (md == qsv_pkg::MODE_READ) begin
      for (int i = 0; i < SIZE; i++) begin
        longint p;
        p = (amp_re[i] * amp_re[i] + amp_im[i] * amp_im[i])
            >>> (2 * qsv_pkg::FRAC_BITS_DEF - 16);
        if (p > 131071) p = 131071;
        r.kind = 1'b1;
        r.basis_index = i[5:0];
        r.probability = p[16:0];
        r.last = (i == SIZE - 1);
        expected_results.push_back(r);
      end
      return;
    end
    case (md)
      qsv_pkg::MODE_MATRIX: if (tq < NQ) begin
        for (int i = 0; i < SIZE; i++) begin
          if ((i & tb) == 0) begin
            j = i | tb;
            ar = amp_re[i]; ai = amp_im[i]; br = amp_re[j]; bi = amp_im[j];
            amp_re[i] = clamp_amp(scale_down(m[0]*ar - m[1]*ai + m[2]*br - m[3]*bi));
            amp_im[i] = clamp_amp(scale_down(m[0]*ai + m[1]*ar + m[2]*bi + m[3]*br));
            amp_re[j] = clamp_amp(scale_down(m[4]*ar - m[5]*ai + m[6]*br - m[7]*bi));
            amp_im[j] = clamp_amp(scale_down(m[4]*ai + m[5]*ar + m[6]*bi + m[7]*br));
          end
        end
      end
      qsv_pkg::MODE_CX: if (tq < NQ && cq < NQ) begin
        for (int i = 0; i < SIZE; i++)
          if ((i & cb) != 0 && (i & tb) == 0) exchange(i, i | tb);
      end
      qsv_pkg::MODE_CZ: if (tq < NQ && cq < NQ) begin
        for (int i = 0; i < SIZE; i++)
          if ((i & cb) != 0 && (i & tb) != 0) begin
            amp_re[i] = clamp_amp(-amp_re[i]);
            amp_im[i] = clamp_amp(-amp_im[i]);
          end
      end
      qsv_pkg::MODE_SWAP: if (tq < NQ && cq < NQ) begin
        for (int i = 0; i < SIZE; i++)
          if ((i & cb) == 0 && (i & tb) != 0) exchange(i, (i | cb) & ~tb);
      end
      qsv_pkg::MODE_CCX: if (tq < NQ && cq < NQ && c2 < NQ) begin
        for (int i = 0; i < SIZE; i++)
          if ((i & cb) != 0 && (i & c2b) != 0 && (i & tb) == 0) exchange(i, i | tb);
      end
      qsv_pkg::MODE_RESET: load_ground();
      default: ;
    endcase
    r = '{kind: 1'b0, basis_index: '0, probability: '0, last: 1'b1};
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    prob_count = 0;
    ack_count = 0;
    load_ground();
  end

  always @(posedge clk) begin
    qsv_tb_pkg::result_item_t want;
    if (!rst) begin
      if (gate.valid && gate.ready) apply_gate();
      if (result.valid && result.ready) begin
        if (result.kind) prob_count++;
        else ack_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction, kind", result.kind, 0);
        end else begin
          want = expected_results.pop_front();
          if (result.kind !== want.kind) report_mismatch("kind", result.kind, want.kind);
          if (result.basis_index !== want.basis_index)
            report_mismatch("basis_index", result.basis_index, want.basis_index);
          if (result.probability !== want.probability)
            report_mismatch("probability", result.probability, want.probability);
          if (result.last !== want.last) report_mismatch("last", result.last, want.last);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/sv/qubit_state_vector_gate_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate engine testbench top
// Drives gate transactions with random gaps and result back-pressure, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module qubit_state_vector_gate_engine_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending, prob_count, ack_count;
  bit calm;

  qsv_gate_if   gate ();
  qsv_result_if result ();

  qubit_state_vector_gate_engine dut (.clk(clk), .rst(rst), .gate(gate), .result(result));

  qsv_checker #(.NQ(qsv_pkg::QUBIT_COUNT_DEF)) u_checker (
    .clk(clk), .rst(rst), .gate(gate), .result(result),
    .fail_count(fail_count), .pending(pending),
    .prob_count(prob_count), .ack_count(ack_count)
  );

  always #5 clk = ~clk;

  function automatic logic signed [17:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 18'sh1FFFF;
      1: return -18'sh20000;
      2: return 18'sh10000;
      3: return 18'sh0B505;
      4: return 18'(int'($urandom_range(0, 4000)) - 2000);
      default: return 18'($urandom());
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next call either replaces or drops it.
  task automatic send_gate(qsv_pkg::mode_t md, int tq, int cq, int c2,
                           logic signed [17:0] ent[8]);
    while (!calm && $urandom_range(0, 99) < 26) begin
      gate.valid <= 1'b0;
      @(negedge clk);
    end
    gate.mode <= md;
    gate.target_qubit <= tq[2:0];
    gate.control_qubit <= cq[2:0];
    gate.second_control_qubit <= c2[2:0];
    {gate.m00_re, gate.m00_im, gate.m01_re, gate.m01_im,
     gate.m10_re, gate.m10_im, gate.m11_re, gate.m11_im} <=
      {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7]};
    gate.valid <= 1'b1;
    do @(posedge clk); while (!gate.ready);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic signed [17:0] ent[8];
    int pick;
    qsv_pkg::mode_t md;
    foreach (ent[k]) ent[k] = rand_entry();
    pick = $urandom_range(0, 99);
    if (pick < 40) md = qsv_pkg::MODE_MATRIX;
    else if (pick < 80) md = qsv_pkg::mode_t'($urandom_range(1, 4));
    else if (pick < 85) md = qsv_pkg::MODE_RESET;
    else if (pick < 97) md = qsv_pkg::MODE_READ;
    else md = qsv_pkg::MODE_NOP;
    // Mostly legal qubits so the store keeps evolving.
    if ($urandom_range(0, 9) == 0)
      send_gate(md, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7), ent);
    else
      send_gate(md, $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5), ent);
  endtask

  // Result back-pressure, decided each falling edge.
  always @(negedge clk)
    result.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);

  initial begin
    logic signed [17:0] hadamard[8], maxed[8], minned[8], zeros[8];
    hadamard = '{18'sh0B505, 0, 18'sh0B505, 0, 18'sh0B505, 0, -18'sh0B505, 0};
    maxed = '{default: 18'sh1FFFF};
    minned = '{default: -18'sh20000};
    zeros = '{default: 18'sh0};
    calm = 1'b0;
    gate.valid = 1'b0;
    gate.mode = qsv_pkg::MODE_NOP;
    gate.target_qubit = '0;
    gate.control_qubit = '0;
    gate.second_control_qubit = '0;
    {gate.m00_re, gate.m00_im, gate.m01_re, gate.m01_im,
     gate.m10_re, gate.m10_im, gate.m11_re, gate.m11_im} = '0;
    result.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: superposition, entangling gates, saturation, odd qubits.
    send_gate(qsv_pkg::MODE_READ, 0, 0, 0, zeros);
    for (int q = 0; q < 6; q++) send_gate(qsv_pkg::MODE_MATRIX, q, 0, 0, hadamard);
    send_gate(qsv_pkg::MODE_CX, 1, 0, 0, zeros);
    send_gate(qsv_pkg::MODE_CZ, 2, 2, 0, zeros);
    send_gate(qsv_pkg::MODE_SWAP, 5, 0, 0, zeros);
    send_gate(qsv_pkg::MODE_CCX, 3, 4, 4, zeros);
    send_gate(qsv_pkg::MODE_CCX, 3, 3, 1, zeros);
    send_gate(qsv_pkg::MODE_CX, 2, 2, 0, zeros);
    send_gate(qsv_pkg::MODE_SWAP, 4, 4, 0, zeros);
    send_gate(qsv_pkg::MODE_READ, 0, 0, 0, zeros);
    send_gate(qsv_pkg::MODE_MATRIX, 0, 0, 0, maxed);
    send_gate(qsv_pkg::MODE_MATRIX, 5, 0, 0, minned);
    send_gate(qsv_pkg::MODE_MATRIX, 5, 0, 0, maxed);
    send_gate(qsv_pkg::MODE_CZ, 0, 0, 0, zeros);
    send_gate(qsv_pkg::MODE_READ, 7, 7, 7, maxed);
    send_gate(qsv_pkg::MODE_MATRIX, 6, 0, 0, zeros);
    send_gate(qsv_pkg::MODE_CX, 7, 6, 0, zeros);
    send_gate(qsv_pkg::MODE_CCX, 0, 1, 7, zeros);
    send_gate(qsv_pkg::MODE_NOP, 7, 7, 7, minned);
    send_gate(qsv_pkg::MODE_RESET, 0, 0, 0, zeros);

    for (int n = 0; n < 380; n++) begin
      calm = (n >= 150 && n < 210);
      send_random();
    end
    gate.valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d acknowledgments and %0d probability readouts",
             ack_count, prob_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Time limit for the slowest run: about 400 gates plus result stalls.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
